### src/console_line_editor_matcher_unit_defines.svh
// assertion macros shared by the checker of the console line editor
// no dependencies; the including module must provide clk and rst_n
`ifndef CONSOLE_LINE_EDITOR_MATCHER_UNIT_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_MATCHER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/cle_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and command tables of the console line editor
// no dependencies
package cle_pkg;

  localparam int LINE_LEN = 64;
  localparam int FILL_W   = $clog2(LINE_LEN + 1);
  localparam int CMD_NUM  = 4;
  localparam int MATCH_W  = 3;
  localparam int BURST_N  = 3;

  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_SP  = 8'd32;
  localparam logic [7:0] CH_DEL = 8'd127;
  localparam logic [7:0] CH_CTL_LO = 8'd17;
  localparam logic [7:0] CH_CTL_HI = 8'd31;

  typedef enum logic [2:0] {
    CODE_LOADIMG   = 3'd0,
    CODE_HELP      = 3'd1,
    CODE_REBOOT    = 3'd2,
    CODE_C         = 3'd3,
    CODE_NOT_FOUND = 3'd4,
    CODE_EMPTY     = 3'd5
  } cmd_code_t;

  typedef enum logic {
    KIND_ECHO   = 1'b0,
    KIND_DECIDE = 1'b1
  } res_kind_t;

  typedef struct packed {
    res_kind_t  kind;
    logic [7:0] echo_char;
    cmd_code_t  command_code;
    logic       last;
  } res_t;

  // up to three result transactions caused by one input byte
  typedef struct packed {
    logic [1:0]              count;
    res_t [BURST_N-1:0]      item;
  } burst_t;

  typedef logic [CMD_NUM-1:0][MATCH_W-1:0] match_vec_t;

  function automatic logic [MATCH_W-1:0] cmd_len(input logic [1:0] idx);
    case (idx)
      2'd0:    cmd_len = 3'd7;
      2'd1:    cmd_len = 3'd4;
      2'd2:    cmd_len = 3'd6;
      default: cmd_len = 3'd1;
    endcase
  endfunction

  // character at position pos of command idx
  function automatic logic [7:0] cmd_char(input logic [1:0] idx,
                                          input logic [MATCH_W-1:0] pos);
    logic [7:0] ch;
    ch = 8'd0;
    case (idx)
      2'd0: begin
        case (pos)
          3'd0:    ch = "l";
          3'd1:    ch = "o";
          3'd2:    ch = "a";
          3'd3:    ch = "d";
          3'd4:    ch = "i";
          3'd5:    ch = "m";
          3'd6:    ch = "g";
          default: ch = 8'd0;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0:    ch = "h";
          3'd1:    ch = "e";
          3'd2:    ch = "l";
          3'd3:    ch = "p";
          default: ch = 8'd0;
        endcase
      end
      2'd2: begin
        case (pos)
          3'd0:    ch = "r";
          3'd1:    ch = "e";
          3'd2:    ch = "b";
          3'd3:    ch = "o";
          3'd4:    ch = "o";
          3'd5:    ch = "t";
          default: ch = 8'd0;
        endcase
      end
      default: begin
        case (pos)
          3'd0:    ch = "c";
          default: ch = 8'd0;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic res_t mk_echo(input logic [7:0] ch, input logic is_last);
    res_t r;
    r.kind         = KIND_ECHO;
    r.echo_char    = ch;
    r.command_code = CODE_LOADIMG;
    r.last         = is_last;
    return r;
  endfunction

  function automatic res_t mk_decide(input cmd_code_t code);
    res_t r;
    r.kind         = KIND_DECIDE;
    r.echo_char    = 8'd0;
    r.command_code = code;
    r.last         = 1'b1;
    return r;
  endfunction

endpackage

### src/cle_match.sv
`timescale 1ns / 1ps
// line state and per-command prefix matching; builds the result burst
// depends on cle_pkg
module cle_match
  import cle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output burst_t     burst
);

  logic [FILL_W-1:0] fill_r, fill_nxt;
  match_vec_t        pm_r, pm_nxt;
  logic [FILL_W-1:0] fill_dec, fill_inc;
  logic              is_nl, is_del, is_drop;

  assign fill_dec = fill_r - FILL_W'(1);
  assign fill_inc = fill_r + FILL_W'(1);
  assign is_nl    = (rx_byte == CH_LF);
  assign is_del   = (rx_byte == CH_DEL);
  assign is_drop  = ((rx_byte >= CH_CTL_LO) && (rx_byte <= CH_CTL_HI)) || rx_byte[7];

  function automatic cmd_code_t decide(input logic [FILL_W-1:0] fill,
                                       input match_vec_t pm);
    cmd_code_t code;
    code = CODE_NOT_FOUND;
    if (fill == '0) begin
      code = CODE_EMPTY;
    end else begin
      for (int i = CMD_NUM - 1; i >= 0; i--) begin
        if (fill == FILL_W'(cmd_len(2'(i))) && FILL_W'(pm[i]) == fill) begin
          code = cmd_code_t'(3'(i));
        end
      end
    end
    return code;
  endfunction

  always_comb begin
    fill_nxt = fill_r;
    pm_nxt   = pm_r;
    burst    = '0;
    if (is_nl) begin
      burst.count   = 2'd3;
      burst.item[0] = mk_echo(CH_CR, 1'b0);
      burst.item[1] = mk_echo(CH_LF, 1'b0);
      burst.item[2] = mk_decide(decide(fill_r, pm_r));
      fill_nxt      = '0;
      pm_nxt        = '0;
    end else if (is_del) begin
      if (fill_r != '0) begin
        fill_nxt = fill_dec;
        for (int i = 0; i < CMD_NUM; i++) begin
          if (FILL_W'(pm_r[i]) > fill_dec) begin
            pm_nxt[i] = fill_dec[MATCH_W-1:0];
          end
        end
        burst.count   = 2'd3;
        burst.item[0] = mk_echo(CH_BS, 1'b0);
        burst.item[1] = mk_echo(CH_SP, 1'b0);
        burst.item[2] = mk_echo(CH_BS, 1'b1);
      end
    end else if (!is_drop) begin
      for (int i = 0; i < CMD_NUM; i++) begin
        if (FILL_W'(pm_r[i]) == fill_r && pm_r[i] < cmd_len(2'(i)) &&
            cmd_char(2'(i), pm_r[i]) == rx_byte) begin
          pm_nxt[i] = pm_r[i] + MATCH_W'(1);
        end
      end
      fill_nxt = fill_inc;
      if (fill_inc >= FILL_W'(LINE_LEN)) begin
        // line full: echo then decision, no cr lf
        burst.count   = 2'd2;
        burst.item[0] = mk_echo(rx_byte, 1'b0);
        burst.item[1] = mk_decide(decide(fill_inc, pm_nxt));
        fill_nxt      = '0;
        pm_nxt        = '0;
      end else begin
        burst.count   = 2'd1;
        burst.item[0] = mk_echo(rx_byte, 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pm_r   <= '0;
    end else if (take) begin
      fill_r <= fill_nxt;
      pm_r   <= pm_nxt;
    end
  end

endmodule

### src/cle_out.sv
`timescale 1ns / 1ps
// result register that drains a burst one transaction per cycle while out_stall is low
// depends on cle_pkg
module cle_out
  import cle_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   take,
  input  burst_t burst_in,
  input  logic   out_stall,
  output logic   in_stall,
  output logic   out_valid,
  output res_t   out_item
);

  res_t [BURST_N-1:0] items_r, items_nxt;
  logic [1:0]         count_r, count_nxt;
  logic               fire;

  assign out_valid = (count_r != 2'd0);
  assign fire      = out_valid && !out_stall;
  assign in_stall  = !((count_r == 2'd0) || (count_r == 2'd1 && !out_stall));
  assign out_item  = items_r[0];

  always_comb begin
    items_nxt = items_r;
    count_nxt = count_r;
    if (take) begin
      items_nxt = burst_in.item;
      count_nxt = burst_in.count;
    end else if (fire) begin
      items_nxt[0] = items_r[1];
      items_nxt[1] = items_r[2];
      count_nxt    = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    items_r <= items_nxt;
  end

endmodule

### src/console_line_editor_matcher_unit.sv
`timescale 1ns / 1ps
// console line editor: echo, backspace handling and command matching
// depends on cle_pkg, cle_match and cle_out
//
// usage
//   in_* channel carries one received console byte per transaction
//   out_* channel carries echo characters (kind 0) and the line-end
//   command decision (kind 1); out_last marks the final transaction
//   caused by one input byte
//   the first result shows on out_* in the cycle after the input
//   transaction is taken
//   results per input byte: one for a plain character, two when it
//   fills the line, three for newline or for backspace on a non-empty
//   line; a byte with no result leaves the result register empty; the
//   result register holds the results of one byte at a time
//   a new byte is taken in the same cycle as the last result leaves
//   reset (rst_n low, synchronous) empties the line and the result register
//   while out_stall is high the current result holds and in_stall rises
//   as soon as no room is left for the next burst
module console_line_editor_matcher_unit
  import cle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_echo_char,
  output logic [2:0] out_command_code,
  output logic       out_last
);

  logic   take;     // input transaction accepted this cycle
  burst_t burst;    // results caused by the current input byte
  res_t   res_item; // head of the result register

  assign take = in_valid && !in_stall;

  // line state update and burst build happen in the cycle of acceptance
  cle_match u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .burst   (burst)
  );

  // burst register drains towards the result channel
  cle_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .burst_in  (burst),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_item  (res_item)
  );

  assign out_kind         = res_item.kind;
  assign out_echo_char    = res_item.echo_char;
  assign out_command_code = res_item.command_code;
  assign out_last         = res_item.last;

endmodule

### src/cle_checker.sv
`timescale 1ns / 1ps
// port-level checks of the console line editor, bound to the top level
// depends on cle_pkg and console_line_editor_matcher_unit_defines.svh
`include "console_line_editor_matcher_unit_defines.svh"
module cle_checker
  import cle_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_kind,
  input logic [7:0] out_echo_char,
  input logic [2:0] out_command_code,
  input logic       out_last
);

  `CLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_kind) && $stable(out_echo_char) &&
    $stable(out_command_code) && $stable(out_last), "stalled result changed")

  `CLE_ASSERT_NOW(a_decide_last, out_valid && out_kind,
    out_last && out_echo_char == 8'd0 && out_command_code <= CODE_EMPTY,
    "malformed decision transaction")

  `CLE_ASSERT_NOW(a_echo_code, out_valid && !out_kind,
    out_command_code == CODE_LOADIMG, "echo transaction carries a command code")

  `CLE_ASSERT_NEXT(a_newline_cr, in_valid && !in_stall && in_rx_byte == CH_LF,
    out_valid && !out_kind && out_echo_char == CH_CR && !out_last,
    "newline did not start with carriage return")

endmodule

bind console_line_editor_matcher_unit cle_checker u_cle_checker (.*);
